@@ hdl/c2s_pkg.sv @@
// Shared constants and types for the Cartesian to spherical converter.
// No dependencies; imported by every module of the block.
`default_nettype none

package c2s_pkg;

  // Angle accumulator: radians times 2^16, signed.
  localparam int ANG_W = 20;
  typedef logic signed [ANG_W-1:0] ang_t;

  localparam int GUARD_BITS = 8;

  // Reciprocal of the limit gain of a long CORDIC chain, times 2^16.
  localparam logic [15:0] GAIN_K = 16'd39797;

  localparam ang_t HALF_PI_Q16 = 20'sd102944;
  localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;
  localparam logic signed [15:0] PI_Q13 = 16'sd25736;

  localparam logic [15:0] EPS_RESET = 16'd1;

  // atan(2^-i) * 2^16, rounded to nearest.
  localparam logic [15:0] ATAN_Q16 [32] = '{
    16'd51472, 16'd30386, 16'd16055, 16'd8150, 16'd4091, 16'd2047, 16'd1024, 16'd512,
    16'd256, 16'd128, 16'd64, 16'd32, 16'd16, 16'd8, 16'd4, 16'd2,
    16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
    16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0
  };

endpackage

`default_nettype wire

@@ hdl/c2s_vec.sv @@
// Pipelined CORDIC vectoring pass: quadrant fold stage plus one stage per iteration.
// Depends on c2s_pkg.
`default_nettype none

module c2s_vec #(
  parameter int W      = 26,
  parameter int SW     = 16,
  parameter int STAGES = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic signed [W-1:0]  x_i,
  input  logic signed [W-1:0]  y_i,
  input  logic [SW-1:0]        side_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [W-1:0]  mag_o,
  output c2s_pkg::ang_t        ang_o,
  output logic [SW-1:0]        side_o
);
  import c2s_pkg::*;

  localparam int N = STAGES + 1;

  logic               v_q    [N];
  logic               stall  [N];
  logic signed [W-1:0] x_q   [N];
  logic signed [W-1:0] y_q   [N];
  ang_t               a_q    [N];
  logic               zero_q [N];
  logic [SW-1:0]      s_q    [N];

  // Fold into the right half plane.
  logic signed [W-1:0] fx_d, fy_d;
  ang_t                fa_d;

  always_comb begin
    fx_d = x_i;
    fy_d = y_i;
    fa_d = '0;
    if (x_i[W-1]) begin
      if (!y_i[W-1]) begin
        fx_d = y_i;
        fy_d = -x_i;
        fa_d = HALF_PI_Q16;
      end else begin
        fx_d = -y_i;
        fy_d = x_i;
        fa_d = -HALF_PI_Q16;
      end
    end
  end

  genvar k;
  generate
    for (k = 0; k < N; k++) begin : g_stage
      if (k == N - 1) begin : g_last
        assign stall[k] = v_q[k] & out_stall_i;
      end else begin : g_mid
        assign stall[k] = v_q[k] & stall[k+1];
      end

      if (k == 0) begin : g_fold
        always_ff @(posedge clk_i or negedge rst_ni) begin
          if (!rst_ni) begin
            v_q[k] <= 1'b0;
          end else if (!stall[k]) begin
            v_q[k] <= in_valid_i;
          end
        end

        always_ff @(posedge clk_i) begin
          if (!stall[k]) begin
            x_q[k]    <= fx_d;
            y_q[k]    <= fy_d;
            a_q[k]    <= fa_d;
            zero_q[k] <= (x_i == '0) && (y_i == '0);
            s_q[k]    <= side_i;
          end
        end
      end else begin : g_iter
        localparam int I = k - 1;
        logic signed [W-1:0] dx, dy;
        ang_t                at;

        assign dx = y_q[k-1] >>> I;
        assign dy = x_q[k-1] >>> I;
        assign at = {{(ANG_W-16){1'b0}}, ATAN_Q16[I]};

        always_ff @(posedge clk_i or negedge rst_ni) begin
          if (!rst_ni) begin
            v_q[k] <= 1'b0;
          end else if (!stall[k]) begin
            v_q[k] <= v_q[k-1];
          end
        end

        always_ff @(posedge clk_i) begin
          if (!stall[k]) begin
            if (!y_q[k-1][W-1]) begin
              x_q[k] <= x_q[k-1] + dx;
              y_q[k] <= y_q[k-1] - dy;
              a_q[k] <= a_q[k-1] + at;
            end else begin
              x_q[k] <= x_q[k-1] - dx;
              y_q[k] <= y_q[k-1] + dy;
              a_q[k] <= a_q[k-1] - at;
            end
            zero_q[k] <= zero_q[k-1];
            s_q[k]    <= s_q[k-1];
          end
        end
      end
    end
  endgenerate

  assign in_stall_o  = stall[0];
  assign out_valid_o = v_q[N-1];
  assign mag_o       = x_q[N-1];
  // atan2(0,0) is defined as zero
  assign ang_o       = zero_q[N-1] ? '0 : a_q[N-1];
  assign side_o      = s_q[N-1];

endmodule

`default_nettype wire

@@ hdl/c2s_scale.sv @@
// Gain compensation stage: rounded multiply by the CORDIC gain constant, then shift.
// Depends on c2s_pkg.
`default_nettype none

module c2s_scale #(
  parameter int W  = 26,
  parameter int OW = 26,
  parameter int SH = 16,
  parameter int SW = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic signed [W-1:0]  mag_i,
  input  logic [SW-1:0]        side_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [OW-1:0] res_o,
  output logic [SW-1:0]        side_o
);
  import c2s_pkg::*;

  localparam int PW = W + 17;
  localparam logic signed [PW-1:0] RND = {{(PW-1){1'b0}}, 1'b1} << (SH - 1);

  logic signed [16:0]   gain_s;
  logic signed [PW-1:0] prod, shifted;
  logic                 v_q, stall;
  logic signed [OW-1:0] res_q;
  logic [SW-1:0]        side_q;

  assign gain_s  = {1'b0, GAIN_K};
  assign prod    = mag_i * gain_s;
  assign shifted = (prod + RND) >>> SH;

  assign stall = v_q & out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (!stall) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall) begin
      res_q  <= shifted[OW-1:0];
      side_q <= side_i;
    end
  end

  assign in_stall_o  = stall;
  assign out_valid_o = v_q;
  assign res_o       = res_q;
  assign side_o      = side_q;

endmodule

`default_nettype wire

@@ hdl/c2s_out.sv @@
// Output register: radius saturation, angle rounding and clamping, zero-length check.
// Depends on c2s_pkg.
`default_nettype none

module c2s_out #(
  parameter int DW = 16,
  parameter int RW = 18
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  c2s_pkg::ang_t        phi_i,
  input  c2s_pkg::ang_t        theta_i,
  input  logic signed [RW-1:0] rad_i,
  input  logic [15:0]          eps_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [15:0]   azimuth_angle_o,
  output logic [14:0]          polar_angle_o,
  output logic [15:0]          radius_o
);
  import c2s_pkg::*;

  localparam int LIM = (DW >= 16) ? 65535 : ((1 << DW) - 1);
  localparam int CW  = (RW > 17) ? RW : 17;
  localparam logic signed [CW-1:0] LIM_C = CW'(LIM);
  localparam ang_t PI_A   = ANG_W'(PI_Q13);
  localparam ang_t NPI_A  = -ANG_W'(PI_Q13);
  localparam ang_t FOUR_A = ANG_W'(4);

  logic signed [CW-1:0] r_ext;
  logic [15:0]          rad_d;
  ang_t                 phr, thr, phc, thc;
  logic signed [15:0]   az_d;
  logic [14:0]          po_d;
  logic                 v_q, stall;
  logic signed [15:0]   az_q;
  logic [14:0]          po_q;
  logic [15:0]          rad_q;

  assign r_ext = CW'(rad_i);
  assign rad_d = (r_ext[CW-1] || (r_ext > LIM_C)) ? 16'(LIM) : r_ext[15:0];

  assign phr = (phi_i + FOUR_A) >>> 3;
  assign thr = (theta_i + FOUR_A) >>> 3;

  always_comb begin
    phc = phr;
    if (phr < NPI_A) phc = NPI_A;
    if (phr > PI_A)  phc = PI_A;
    thc = thr;
    if (thr[ANG_W-1]) thc = '0;
    if (thr > PI_A)   thc = PI_A;
    if (rad_d < eps_i) begin
      az_d = HALF_PI_Q13;
      po_d = HALF_PI_Q13[14:0];
    end else begin
      az_d = phc[15:0];
      po_d = thc[14:0];
    end
  end

  assign stall = v_q & out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (!stall) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall) begin
      az_q  <= az_d;
      po_q  <= po_d;
      rad_q <= rad_d;
    end
  end

  assign in_stall_o      = stall;
  assign out_valid_o     = v_q;
  assign azimuth_angle_o = az_q;
  assign polar_angle_o   = po_q;
  assign radius_o        = rad_q;

endmodule

`default_nettype wire

@@ hdl/cartesian_to_spherical_top.sv @@
// Top level of the Cartesian to spherical converter (two CORDIC vectoring pipelines).
// Depends on c2s_pkg, c2s_vec, c2s_scale and c2s_out.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+-------------------------------------------
//  input    | in_valid_i / in_stall_o      | coord_x_i, coord_y_i, coord_z_i
//  output   | out_valid_o / out_stall_i    | azimuth_angle_o, polar_angle_o, radius_o
//  config   | cfg_we_i (no stall)          | cfg_wdata_i -> radius_epsilon
//
// One item per cycle while out_stall_i is low; the pipeline has one register stage per
//   CORDIC iteration in each of the two passes plus fold, gain and output stages.
// Reset clears all valid bits and sets radius_epsilon to 1; no clearing pass.
// Every stage holds only while it is full and the stage after it stalls, so
//   bubbles collapse and items keep entering behind a held result until every stage is full.
`default_nettype none

module cartesian_to_spherical_top #(
  parameter int DATA_WIDTH    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [15:0]                  cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [DATA_WIDTH-1:0] coord_x_i,
  input  logic signed [DATA_WIDTH-1:0] coord_y_i,
  input  logic signed [DATA_WIDTH-1:0] coord_z_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [15:0]           azimuth_angle_o,
  output logic [14:0]                  polar_angle_o,
  output logic [15:0]                  radius_o
);
  import c2s_pkg::*;

  // Datapath width: inputs times 2^8, plus headroom for CORDIC growth
  localparam int W  = DATA_WIDTH + GUARD_BITS + 2;
  localparam int RW = DATA_WIDTH + 2;

  logic [15:0] eps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EPS_RESET;
    end else if (cfg_we_i) begin
      eps_q <= cfg_wdata_i;
    end
  end

  // Guarded operands
  logic signed [W-1:0] gx, gy;
  assign gx = W'($signed({coord_x_i, {GUARD_BITS{1'b0}}}));
  assign gy = W'($signed({coord_y_i, {GUARD_BITS{1'b0}}}));

  // Pass one over (x, y): azimuth and planar magnitude
  logic                  v1, st1;
  logic signed [W-1:0]   mag1;
  ang_t                  ang1;
  logic [DATA_WIDTH-1:0] z1;

  c2s_vec #(.W(W), .SW(DATA_WIDTH), .STAGES(CORDIC_STAGES)) u_vec1 (
    .clk_i, .rst_ni,
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .x_i        (gx),
    .y_i        (gy),
    .side_i     (coord_z_i),
    .out_valid_o(v1),
    .out_stall_i(st1),
    .mag_o      (mag1),
    .ang_o      (ang1),
    .side_o     (z1)
  );

  // Planar magnitude, gain compensated
  logic                         v2, st2;
  logic signed [W-1:0]          rxy;
  logic [DATA_WIDTH+ANG_W-1:0]  sd2;
  logic signed [DATA_WIDTH-1:0] z2;
  ang_t                         phi2;

  c2s_scale #(.W(W), .OW(W), .SH(16), .SW(DATA_WIDTH + ANG_W)) u_scale1 (
    .clk_i, .rst_ni,
    .in_valid_i (v1),
    .in_stall_o (st1),
    .mag_i      (mag1),
    .side_i     ({z1, ang1}),
    .out_valid_o(v2),
    .out_stall_i(st2),
    .res_o      (rxy),
    .side_o     (sd2)
  );

  assign z2   = sd2[DATA_WIDTH+ANG_W-1:ANG_W];
  assign phi2 = sd2[ANG_W-1:0];

  logic signed [W-1:0] gz;
  assign gz = W'($signed({z2, {GUARD_BITS{1'b0}}}));

  // Pass two over (z, planar magnitude): polar angle and radius
  logic                v3, st3;
  logic signed [W-1:0] mag2;
  ang_t                ang2, phi3;

  c2s_vec #(.W(W), .SW(ANG_W), .STAGES(CORDIC_STAGES)) u_vec2 (
    .clk_i, .rst_ni,
    .in_valid_i (v2),
    .in_stall_o (st2),
    .x_i        (gz),
    .y_i        (rxy),
    .side_i     (phi2),
    .out_valid_o(v3),
    .out_stall_i(st3),
    .mag_o      (mag2),
    .ang_o      (ang2),
    .side_o     (phi3)
  );

  logic                 v4, st4;
  logic signed [RW-1:0] rad4;
  logic [2*ANG_W-1:0]   sd4;
  ang_t                 phi4, theta4;

  c2s_scale #(.W(W), .OW(RW), .SH(24), .SW(2 * ANG_W)) u_scale2 (
    .clk_i, .rst_ni,
    .in_valid_i (v3),
    .in_stall_o (st3),
    .mag_i      (mag2),
    .side_i     ({phi3, ang2}),
    .out_valid_o(v4),
    .out_stall_i(st4),
    .res_o      (rad4),
    .side_o     (sd4)
  );

  assign phi4   = sd4[2*ANG_W-1:ANG_W];
  assign theta4 = sd4[ANG_W-1:0];

  // Rounding, clamping, zero-length override; output register
  c2s_out #(.DW(DATA_WIDTH), .RW(RW)) u_out (
    .clk_i, .rst_ni,
    .in_valid_i     (v4),
    .in_stall_o     (st4),
    .phi_i          (phi4),
    .theta_i        (theta4),
    .rad_i          (rad4),
    .eps_i          (eps_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .azimuth_angle_o(azimuth_angle_o),
    .polar_angle_o  (polar_angle_o),
    .radius_o       (radius_o)
  );

  // Input backpressure can only originate from a held result.
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  a_az_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (azimuth_angle_o >= -PI_Q13) && (azimuth_angle_o <= PI_Q13))
    else $error("azimuth out of range");

  a_polar_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, polar_angle_o} <= PI_Q13))
    else $error("polar angle out of range");

endmodule

`default_nettype wire
